>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> design/stpsd_pkg.sv
`default_nettype none

package stpsd_pkg;

    // Default and widths
    localparam int WINDOW_DEF = 64;
    localparam int SAMPLE_W   = 16;
    localparam int BIN_W      = 6;
    localparam int DB_W       = 13;
    localparam int COEF_W     = 17;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 41;
    localparam int MAG_W      = 31;
    localparam int PWR_W      = 62;
    localparam int EXP_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int LOG_W      = EXP_W + FRAC_W + 1;

    // dB conversion constants
    localparam logic signed [LOG_W-1:0]  LOG_OFFSET = LOG_W'(48 * 65536);
    localparam logic signed [MUL_W-1:0]  DB_SCALE   = MUL_W'(3156528);
    localparam logic signed [DB_W-1:0]   DB_FLOOR   = -13'sd3200;
    localparam logic signed [DB_W-1:0]   DB_CEIL    = 13'sd640;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRD,
        ST_WMUL,
        ST_WWR,
        ST_MRD,
        ST_MRE,
        ST_MIM,
        ST_MACC,
        ST_RND,
        ST_PRE,
        ST_PIM,
        ST_PSUM,
        ST_NORM,
        ST_LMUL,
        ST_LUPD,
        ST_DBMUL,
        ST_DBFIN,
        ST_OUT
    } stpsd_state_t;

    // Quarter-wave sine series, Q30 result, t in 0..16384 (2^-16 turn)
    function automatic longint unsigned sin_quarter(input longint unsigned t);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned one;
        one = 64'd1 << 30;
        x   = t * 64'd102944;
        x2  = (x * x) >> 30;
        h   = one - x2 / 64'd110;
        h   = one - ((x2 * h) >> 30) / 64'd72;
        h   = one - ((x2 * h) >> 30) / 64'd42;
        h   = one - ((x2 * h) >> 30) / 64'd20;
        h   = one - ((x2 * h) >> 30) / 64'd6;
        return (x * h) >> 30;
    endfunction

    // Cosine in Q15 for a phase in 2^-16 turn, clamped to +/-32768
    function automatic logic signed [COEF_W-1:0] cos_q15(input int unsigned phase);
        int unsigned     p;
        int unsigned     q;
        int unsigned     r;
        longint unsigned mag;
        logic            neg;
        logic signed [COEF_W-1:0] m;
        p = phase & 32'hFFFF;
        q = p >> 14;
        r = p & 32'd16383;
        case (q)
            0:       begin mag = sin_quarter(64'(16384 - r)); neg = 1'b0; end
            1:       begin mag = sin_quarter(64'(r));         neg = 1'b1; end
            2:       begin mag = sin_quarter(64'(16384 - r)); neg = 1'b1; end
            default: begin mag = sin_quarter(64'(r));         neg = 1'b0; end
        endcase
        mag = (mag + 64'd16384) >> 15;
        if (mag > 64'd32768)
        begin
            mag = 64'd32768;
        end
        m = COEF_W'(mag);
        return neg ? -m : m;
    endfunction

endpackage

`default_nettype wire

>>> design/stft_power_spectrum_db_core.sv
// An item that completes no frame is taken without a stall.
// The item that completes a frame is taken, then keeps the input stalled
// until the last bin of the frame has been taken at the output; that time
// is set by output waits, the one shared 33x33 multiplier and the
// bit-per-cycle normalize of each bin's power.
// rst_n is asynchronous, active low: it clears fill, hop and pointer state and
// the sequencer; the sample store holds no reset value.
`default_nettype none

module stft_power_spectrum_db_core
    import stpsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [BIN_W-1:0]                bin_index,
    output logic signed [DB_W-1:0]          power_db,
    output logic                            last_bin
);

    localparam int AW     = $clog2(WINDOW);
    localparam int HOP    = WINDOW / 4;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int HOP_W  = $clog2(HOP + 1);

    // Constant coefficient tables
    logic signed [COEF_W-1:0] hann_tab [WINDOW];
    logic signed [COEF_W-1:0] cos_tab  [WINDOW];
    logic signed [COEF_W-1:0] sin_tab  [WINDOW];

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_tab
        localparam int HPH = ((g * 65536 + (WINDOW - 1) / 2) / (WINDOW - 1)) % 65536;
        localparam int HC  = int'(cos_q15(HPH));
        localparam int HWT = (32768 - HC) / 2;
        localparam int DPH = (g * 65536 + WINDOW / 2) / WINDOW;
        localparam int SPH = (DPH + 49152) % 65536;
        assign hann_tab[g] = COEF_W'(HWT);
        assign cos_tab[g]  = cos_q15(DPH);
        assign sin_tab[g]  = cos_q15(SPH);
    end

    // Control registers
    stpsd_state_t      state_reg;
    stpsd_state_t      state_next;
    logic [FILL_W-1:0] fill_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic [AW-1:0]     wptr_reg;

    // Datapath registers
    logic [AW-1:0]              n_reg;
    logic [AW-1:0]              idx_reg;
    logic [BIN_W-1:0]           k_reg;
    logic signed [SAMPLE_W-1:0] st_q_reg;
    logic signed [COEF_W-1:0]   xw_q_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_re_reg;
    logic signed [ACC_W-1:0]    acc_im_reg;
    logic [MAG_W-1:0]           rmag_reg;
    logic [MAG_W-1:0]           imag_reg;
    logic [PWR_W-1:0]           v_reg;
    logic [EXP_W-1:0]           e_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [31:0]                y_reg;
    logic [3:0]                 it_reg;
    logic [BIN_W-1:0]           bin_reg;
    logic signed [DB_W-1:0]     db_reg;
    logic                       last_reg;

    // Memories
    logic signed [SAMPLE_W-1:0] store_mem [WINDOW];
    logic signed [COEF_W-1:0]   xw_mem    [WINDOW];

    logic                     in_acc;
    logic                     frame_go;
    logic [AW:0]              rd_sum;
    logic [AW-1:0]            rd_addr;
    logic [AW:0]              idx_sum;
    logic [AW-1:0]            idx_wrap;
    logic                     n_last;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0]        wmag;
    logic [COEF_W-1:0]        wrnd;
    logic signed [COEF_W-1:0] xw_val;
    logic [ACC_W-1:0]         re_abs;
    logic [ACC_W-1:0]         im_abs;
    logic [PWR_W-1:0]         psum;
    logic [32:0]              lsq;
    logic signed [LOG_W-1:0]  lsub;
    logic signed [PROD_W-1:0] dsum;
    logic signed [33:0]       dq;
    logic signed [DB_W-1:0]   db_val;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign n_last   = (n_reg == AW'(WINDOW - 1));

    // Decide whether this item closes a frame
    always_comb
    begin
        if (fill_reg < FILL_W'(WINDOW))
        begin
            frame_go = (fill_reg == FILL_W'(WINDOW - 1));
        end
        else
        begin
            frame_go = (hop_reg == HOP_W'(HOP - 1));
        end
    end

    // Oldest-first read address and running DFT index, both modulo WINDOW
    always_comb
    begin
        rd_sum   = {1'b0, wptr_reg} + {1'b0, n_reg};
        rd_addr  = (rd_sum >= (AW+1)'(WINDOW)) ? AW'(rd_sum - (AW+1)'(WINDOW)) : AW'(rd_sum);
        idx_sum  = {1'b0, idx_reg} + (AW+1)'(k_reg);
        idx_wrap = (idx_sum >= (AW+1)'(WINDOW)) ? AW'(idx_sum - (AW+1)'(WINDOW))
                                                : AW'(idx_sum);
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_WMUL:
            begin
                mul_a = MUL_W'(st_q_reg);
                mul_b = MUL_W'(hann_tab[n_reg]);
            end
            ST_MRE:
            begin
                mul_a = MUL_W'(xw_q_reg);
                mul_b = MUL_W'(cos_tab[idx_reg]);
            end
            ST_MIM:
            begin
                mul_a = MUL_W'(xw_q_reg);
                mul_b = MUL_W'(sin_tab[idx_reg]);
            end
            ST_PRE:
            begin
                mul_a = {2'b00, rmag_reg};
                mul_b = {2'b00, rmag_reg};
            end
            ST_PIM:
            begin
                mul_a = {2'b00, imag_reg};
                mul_b = {2'b00, imag_reg};
            end
            ST_LMUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            ST_DBMUL:
            begin
                mul_a = MUL_W'(lsub);
                mul_b = DB_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding, magnitude and log helpers
    always_comb
    begin
        wmag   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        wrnd   = COEF_W'((wmag + PROD_W'(16384)) >> 15);
        xw_val = prod_reg[PROD_W-1] ? -$signed(wrnd) : $signed(wrnd);
        re_abs = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
        im_abs = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
        psum   = v_reg + prod_reg[PWR_W-1:0];
        lsq    = prod_reg[63:31];
        lsub   = $signed({1'b0, e_reg, frac_reg}) - LOG_OFFSET;
        dsum   = prod_reg + PROD_W'(64'sd2147483648);
        dq     = dsum[PROD_W-1:32];
        if (dq < 34'(DB_FLOOR))
        begin
            db_val = DB_FLOOR;
        end
        else if (dq > 34'(DB_CEIL))
        begin
            db_val = DB_CEIL;
        end
        else
        begin
            db_val = DB_W'(dq);
        end
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && frame_go)
                begin
                    state_next = ST_WRD;
                end
            end
            ST_WRD:   state_next = ST_WMUL;
            ST_WMUL:  state_next = ST_WWR;
            ST_WWR:   state_next = n_last ? ST_MRD : ST_WRD;
            ST_MRD:   state_next = ST_MRE;
            ST_MRE:   state_next = ST_MIM;
            ST_MIM:   state_next = ST_MACC;
            ST_MACC:  state_next = n_last ? ST_RND : ST_MRD;
            ST_RND:   state_next = ST_PRE;
            ST_PRE:   state_next = ST_PIM;
            ST_PIM:   state_next = ST_PSUM;
            ST_PSUM:  state_next = (psum == '0) ? ST_OUT : ST_NORM;
            ST_NORM:  state_next = v_reg[PWR_W-1] ? ST_LMUL : ST_NORM;
            ST_LMUL:  state_next = ST_LUPD;
            ST_LUPD:  state_next = (it_reg == 4'd15) ? ST_DBMUL : ST_LMUL;
            ST_DBMUL: state_next = ST_DBFIN;
            ST_DBFIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? ST_IDLE : ST_MRD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Hold state, fill, hop and write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            hop_reg   <= '0;
            wptr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                wptr_reg <= (wptr_reg == AW'(WINDOW - 1)) ? '0 : wptr_reg + 1'b1;
                if (fill_reg < FILL_W'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                    hop_reg  <= '0;
                end
                else if (frame_go)
                begin
                    hop_reg <= '0;
                end
                else
                begin
                    hop_reg <= hop_reg + 1'b1;
                end
            end
        end
    end

    // Sample store and windowed-sample store
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            store_mem[wptr_reg] <= sample;
        end
        st_q_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WWR)
        begin
            xw_mem[n_reg] <= xw_val;
        end
        xw_q_reg <= xw_mem[n_reg];
    end

    // Shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Advance the datapath per step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg <= '0;
            end
            ST_WWR:
            begin
                if (n_last)
                begin
                    n_reg      <= '0;
                    idx_reg    <= '0;
                    k_reg      <= '0;
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            ST_MIM:
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(prod_reg);
            end
            ST_MACC:
            begin
                acc_im_reg <= acc_im_reg - ACC_W'(prod_reg);
                idx_reg    <= idx_wrap;
                n_reg      <= n_reg + 1'b1;
            end
            ST_RND:
            begin
                rmag_reg <= MAG_W'((re_abs + ACC_W'(32)) >> 6);
                imag_reg <= MAG_W'((im_abs + ACC_W'(32)) >> 6);
                bin_reg  <= k_reg;
                last_reg <= (k_reg == BIN_W'(WINDOW / 2));
            end
            ST_PIM:
            begin
                v_reg <= prod_reg[PWR_W-1:0];
            end
            ST_PSUM:
            begin
                v_reg  <= psum;
                e_reg  <= EXP_W'(PWR_W - 1);
                db_reg <= DB_FLOOR;
            end
            ST_NORM:
            begin
                if (v_reg[PWR_W-1])
                begin
                    y_reg    <= v_reg[PWR_W-1 -: 32];
                    frac_reg <= '0;
                    it_reg   <= '0;
                end
                else
                begin
                    v_reg <= {v_reg[PWR_W-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
            end
            ST_LUPD:
            begin
                frac_reg <= {frac_reg[FRAC_W-2:0], lsq[32]};
                y_reg    <= lsq[32] ? lsq[32:1] : lsq[31:0];
                it_reg   <= it_reg + 1'b1;
            end
            ST_DBFIN:
            begin
                db_reg <= db_val;
            end
            ST_OUT:
            begin
                if (!out_stall && !last_reg)
                begin
                    k_reg      <= k_reg + 1'b1;
                    n_reg      <= '0;
                    idx_reg    <= '0;
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Drive the result item
    assign out_valid = (state_reg == ST_OUT);
    assign bin_index = bin_reg;
    assign power_db  = db_reg;
    assign last_bin  = last_reg;

endmodule

`default_nettype wire

>>> design/stpsd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module stpsd_checker
    import stpsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [BIN_W-1:0]           bin_index,
    input wire logic signed [DB_W-1:0]     power_db,
    input wire logic                       last_bin
);

    // A pending result keeps the input side busy
    `AST_IMPLY(a_busy_out, clk, rst_n, out_valid, in_stall)
    // A stalled result holds
    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(power_db) && $stable(bin_index))
    // Last bin flag sits on the top bin only
    `AST_IMPLY(a_last_idx, clk, rst_n, out_valid && last_bin, bin_index == BIN_W'(WINDOW / 2))
    // After a non-final bin the frame goes on
    `AST_NEXT(a_bin_step, clk, rst_n, out_valid && !out_stall && !last_bin, in_stall)
    // Power stays within the clamp
    `AST_IMPLY(a_db_range, clk, rst_n, out_valid, (power_db >= DB_FLOOR) && (power_db <= DB_CEIL))

endmodule

bind stft_power_spectrum_db_core stpsd_checker #(.WINDOW(WINDOW)) u_stpsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_index (bin_index),
    .power_db  (power_db),
    .last_bin  (last_bin)
);

`default_nettype wire

>>> tb/stpsd_scoreboard.sv
`timescale 1ns / 100ps
`default_nettype none

module stpsd_scoreboard
    import stpsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [BIN_W-1:0]           bin_index,
    input  wire logic signed [DB_W-1:0]     power_db,
    input  wire logic                       last_bin,
    output int                              mismatches,
    output int                              bins_pending,
    output int                              bins_checked,
    output int                              frames_seen
);

    localparam int HOP   = WINDOW / 4;
    localparam int NBINS = WINDOW / 2 + 1;

    typedef struct packed {
        logic [BIN_W-1:0]       bin;
        logic signed [DB_W-1:0] db;
        logic                   last;
    } spectrum_bin_t;

    spectrum_bin_t  bin_queue[$];
    int             pcm_window[WINDOW];
    int             samples_held;
    int             since_frame;

    // quarter-wave sine, t in 0..16384 of 2^-16 turn, Q30
    function automatic longint unsigned quarter_sine_q30(input longint unsigned t);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned unity;
        unity = 64'd1 << 30;
        x  = t * 64'd102944;
        x2 = (x * x) >> 30;
        h  = unity - x2 / 110;
        h  = unity - ((x2 * h) >> 30) / 72;
        h  = unity - ((x2 * h) >> 30) / 42;
        h  = unity - ((x2 * h) >> 30) / 20;
        h  = unity - ((x2 * h) >> 30) / 6;
        return (x * h) >> 30;
    endfunction

    function automatic longint cosine_q15(input int unsigned phase);
        int unsigned     quadrant;
        int unsigned     rem_t;
        longint unsigned amp;
        logic            flip;
        quadrant = (phase & 32'hFFFF) >> 14;
        rem_t    = phase & 32'd16383;
        flip     = (quadrant == 1) || (quadrant == 2);
        if (quadrant == 0 || quadrant == 2)
        begin
            amp = quarter_sine_q30(64'(16384 - rem_t));
        end
        else
        begin
            amp = quarter_sine_q30(64'(rem_t));
        end
        amp = (amp + 64'd16384) >> 15;
        if (amp > 64'd32768)
        begin
            amp = 64'd32768;
        end
        return flip ? -longint'(amp) : longint'(amp);
    endfunction

    // round half away from zero, dropping sh bits
    function automatic longint round_away(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // power in Q48 to 1/16 dB, floor and ceiling applied
    function automatic logic signed [DB_W-1:0] power_to_db(input longint unsigned p);
        int              msb;
        longint unsigned y;
        longint unsigned frac;
        longint          scaled;
        longint unsigned biased;
        longint          db;
        if (p == 0)
        begin
            return DB_FLOOR;
        end
        msb = 63;
        while (p[msb] == 1'b0)
        begin
            msb--;
        end
        y = (msb >= 31) ? (p >> (msb - 31)) : (p << (31 - msb));
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32))
            begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        scaled = (longint'((msb << 16) | frac) - 48 * 65536) * 64'sd3156528;
        biased = scaled + (64'sd4096 << 32) + (64'sd1 << 31);
        db = longint'(biased >> 32) - 4096;
        if (db < DB_FLOOR)
        begin
            db = DB_FLOOR;
        end
        if (db > DB_CEIL)
        begin
            db = DB_CEIL;
        end
        return DB_W'(db);
    endfunction

    // window, transform and queue one frame of bins
    task automatic predict_frame();
        longint        tapered[WINDOW];
        longint        weight;
        longint        re;
        longint        im;
        longint        r_mag;
        longint        i_mag;
        int unsigned   ph;
        int unsigned   idx;
        spectrum_bin_t b;
        for (int n = 0; n < WINDOW; n++)
        begin
            ph = (n * 65536 + (WINDOW - 1) / 2) / (WINDOW - 1);
            weight = (32768 - cosine_q15(ph)) >>> 1;
            tapered[n] = round_away(longint'(pcm_window[n]) * weight, 15);
        end
        for (int k = 0; k < NBINS; k++)
        begin
            re = 0;
            im = 0;
            for (int n = 0; n < WINDOW; n++)
            begin
                idx = (k * n) % WINDOW;
                ph  = (idx * 65536 + WINDOW / 2) / WINDOW;
                re += tapered[n] * cosine_q15(ph);
                im -= tapered[n] * cosine_q15((ph + 49152) & 32'hFFFF);
            end
            re = round_away(re, 6);
            im = round_away(im, 6);
            r_mag = (re < 0) ? -re : re;
            i_mag = (im < 0) ? -im : im;
            b.bin  = BIN_W'(k);
            b.db   = power_to_db(longint'(r_mag * r_mag) + longint'(i_mag * i_mag));
            b.last = (k == NBINS - 1);
            bin_queue.push_back(b);
        end
        frames_seen++;
    endtask

    assign bins_pending = bin_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        spectrum_bin_t want;
        if (!rst_n)
        begin
            samples_held <= 0;
            since_frame  <= 0;
            mismatches   <= 0;
            bins_checked <= 0;
            frames_seen  = 0;
            bin_queue.delete();
        end
        else
        begin
            // take a sample into the window, frame on fill and every hop
            if (in_valid && !in_stall)
            begin
                if (samples_held < WINDOW)
                begin
                    pcm_window[samples_held] = sample;
                    samples_held <= samples_held + 1;
                    if (samples_held == WINDOW - 1)
                    begin
                        since_frame <= 0;
                        predict_frame();
                    end
                end
                else
                begin
                    for (int i = 0; i < WINDOW - 1; i++)
                    begin
                        pcm_window[i] = pcm_window[i + 1];
                    end
                    pcm_window[WINDOW - 1] = sample;
                    if (since_frame + 1 >= HOP)
                    begin
                        since_frame <= 0;
                        predict_frame();
                    end
                    else
                    begin
                        since_frame <= since_frame + 1;
                    end
                end
            end
            // compare each bin against the oldest prediction
            if (out_valid && !out_stall)
            begin
                bins_checked <= bins_checked + 1;
                if (bin_queue.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected bin %0d db %0d last %0b",
                                 $realtime, bin_index, power_db, last_bin);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = bin_queue.pop_front();
                    if (want.bin !== bin_index || want.db !== power_db
                        || want.last !== last_bin)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: bin exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     $realtime, want.bin, want.db, want.last,
                                     bin_index, power_db, last_bin);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_stft_power_spectrum_db_core.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_stft_power_spectrum_db_core;
    import stpsd_pkg::*;

    localparam int WINDOW     = WINDOW_DEF;
    localparam int HOP        = WINDOW / 4;
    localparam int IDLE_LIMIT = 100000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [BIN_W-1:0]           bin_index;
    logic signed [DB_W-1:0]     power_db;
    logic                       last_bin;

    int   mismatches;
    int   bins_pending;
    int   bins_checked;
    int   frames_seen;
    int   items_sent;
    int   idle_cycles;
    logic steady;

    stft_power_spectrum_db_core #(.WINDOW(WINDOW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_index (bin_index),
        .power_db  (power_db),
        .last_bin  (last_bin)
    );

    stpsd_scoreboard #(.WINDOW(WINDOW)) u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bin_index    (bin_index),
        .power_db     (power_db),
        .last_bin     (last_bin),
        .mismatches   (mismatches),
        .bins_pending (bins_pending),
        .bins_checked (bins_checked),
        .frames_seen  (frames_seen)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // stall the output side at random outside the steady stretch
    always @(posedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 10);
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one sample and hold it until taken
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        if (!steady && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // one hop of samples in a random style
    task automatic send_hop(input int style);
        int   amp;
        int   step;
        int   phase;
        logic signed [SAMPLE_W-1:0] s;
        amp   = $urandom_range(1, 32767);
        step  = $urandom_range(0, 8191);
        phase = $urandom;
        for (int i = 0; i < HOP; i++)
        begin
            case (style)
                0:       s = 16'sd0;
                1:       s = SAMPLE_W'($urandom);
                2:       s = SAMPLE_W'($signed($urandom_range(0, 2 * amp)) - amp);
                3:       s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                default: s = (phase[15]) ? SAMPLE_W'(amp) : SAMPLE_W'(-amp);
            endcase
            phase += step;
            send_sample(s);
        end
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] edge_vals[12];
        int style;
        logic drained;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        out_stall   = 1'b0;
        steady      = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        drained     = 1'b0;
        edge_vals = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sh7FFF,
                      16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0001, 16'shFFFE, 16'sh4000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and toggling patterns open the first window
        foreach (edge_vals[i])
        begin
            send_sample(edge_vals[i]);
        end
        for (int i = 0; i < 12; i++)
        begin
            send_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
        end

        // random hops; a silent pick sends five hops, long enough to zero the whole window
        while (items_sent < 360)
        begin
            if (items_sent >= 120 && items_sent < 200)
            begin
                steady = 1'b1;
            end
            else
            begin
                steady = 1'b0;
            end
            style = $urandom_range(0, 9);
            if (items_sent >= 24 && items_sent < 40)
            begin
                style = 3;
            end
            if (style == 0)
            begin
                repeat (5) send_hop(0);
            end
            else
            begin
                send_hop(style % 5);
            end
            // drain all bins once mid-run before going on
            if (!drained && items_sent >= 240)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (bins_pending != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        // wait for the last frame to come out
        while (bins_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        $display("Sent %0d samples; %0d frames predicted, %0d bins compared.",
                 items_sent, frames_seen, bins_checked);
        $display("Covered full-scale, toggling, silent, noise and tone windows.");
        if (mismatches == 0 && bins_pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
